>>> rtl/sc2a_pkg.sv
// Package for the scan code set 1 to ASCII translator.
// Holds scan code constants, the modifier flag type and the three key tables.
// No dependencies.
package sc2a_pkg;

    // Modifier and prefix scan codes (set 1, make codes)
    localparam logic [7:0] SC_LSHIFT  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT  = 8'h36;
    localparam logic [7:0] SC_CAPS    = 8'h3A;
    localparam logic [7:0] SC_CTRL    = 8'h1D;
    localparam logic [7:0] SC_ALT     = 8'h38;
    localparam logic [7:0] SC_EXTPFX  = 8'hE0;

    // Table lengths: normal/shifted and control
    localparam logic [7:0] PLAIN_LEN  = 8'd58;
    localparam logic [7:0] CTRL_LEN   = 8'd51;

    // Alt sets the top bit of the character
    localparam logic [7:0] ALT_OFFSET = 8'h80;

    // Modifier flags; packs to bit0 shift .. bit4 extended
    typedef struct packed {
        logic ext;
        logic alt;
        logic ctrl;
        logic caps;
        logic shift;
    } flags_t;

    // Normal (unshifted) table
    function automatic logic [7:0] plain_lookup(input logic [5:0] idx);
        logic [7:0] ch;
        case (idx)
            6'd1:  ch = 8'h1B;
            6'd2:  ch = 8'h31;
            6'd3:  ch = 8'h32;
            6'd4:  ch = 8'h33;
            6'd5:  ch = 8'h34;
            6'd6:  ch = 8'h35;
            6'd7:  ch = 8'h36;
            6'd8:  ch = 8'h37;
            6'd9:  ch = 8'h38;
            6'd10: ch = 8'h39;
            6'd11: ch = 8'h30;
            6'd12: ch = 8'h2D;
            6'd13: ch = 8'h3D;
            6'd14: ch = 8'h08;
            6'd15: ch = 8'h09;
            6'd16: ch = 8'h71;
            6'd17: ch = 8'h77;
            6'd18: ch = 8'h65;
            6'd19: ch = 8'h72;
            6'd20: ch = 8'h74;
            6'd21: ch = 8'h79;
            6'd22: ch = 8'h75;
            6'd23: ch = 8'h69;
            6'd24: ch = 8'h6F;
            6'd25: ch = 8'h70;
            6'd26: ch = 8'h5B;
            6'd27: ch = 8'h5D;
            6'd28: ch = 8'h0A;
            6'd30: ch = 8'h61;
            6'd31: ch = 8'h73;
            6'd32: ch = 8'h64;
            6'd33: ch = 8'h66;
            6'd34: ch = 8'h67;
            6'd35: ch = 8'h68;
            6'd36: ch = 8'h6A;
            6'd37: ch = 8'h6B;
            6'd38: ch = 8'h6C;
            6'd39: ch = 8'h3B;
            6'd40: ch = 8'h27;
            6'd41: ch = 8'h60;
            6'd43: ch = 8'h5C;
            6'd44: ch = 8'h7A;
            6'd45: ch = 8'h78;
            6'd46: ch = 8'h63;
            6'd47: ch = 8'h76;
            6'd48: ch = 8'h62;
            6'd49: ch = 8'h6E;
            6'd50: ch = 8'h6D;
            6'd51: ch = 8'h2C;
            6'd52: ch = 8'h2E;
            6'd53: ch = 8'h2F;
            6'd57: ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Shifted table
    function automatic logic [7:0] upper_lookup(input logic [5:0] idx);
        logic [7:0] ch;
        case (idx)
            6'd2:  ch = 8'h21;
            6'd3:  ch = 8'h40;
            6'd4:  ch = 8'h23;
            6'd5:  ch = 8'h24;
            6'd6:  ch = 8'h25;
            6'd7:  ch = 8'h5E;
            6'd8:  ch = 8'h26;
            6'd9:  ch = 8'h2A;
            6'd10: ch = 8'h28;
            6'd11: ch = 8'h29;
            6'd12: ch = 8'h5F;
            6'd13: ch = 8'h2B;
            6'd14: ch = 8'h08;
            6'd15: ch = 8'h09;
            6'd16: ch = 8'h51;
            6'd17: ch = 8'h57;
            6'd18: ch = 8'h45;
            6'd19: ch = 8'h52;
            6'd20: ch = 8'h54;
            6'd21: ch = 8'h59;
            6'd22: ch = 8'h55;
            6'd23: ch = 8'h49;
            6'd24: ch = 8'h4F;
            6'd25: ch = 8'h50;
            6'd26: ch = 8'h7B;
            6'd27: ch = 8'h7D;
            6'd28: ch = 8'h0A;
            6'd30: ch = 8'h41;
            6'd31: ch = 8'h53;
            6'd32: ch = 8'h44;
            6'd33: ch = 8'h46;
            6'd34: ch = 8'h47;
            6'd35: ch = 8'h48;
            6'd36: ch = 8'h4A;
            6'd37: ch = 8'h4B;
            6'd38: ch = 8'h4C;
            6'd39: ch = 8'h3A;
            6'd40: ch = 8'h22;
            6'd41: ch = 8'h7E;
            6'd43: ch = 8'h7C;
            6'd44: ch = 8'h5A;
            6'd45: ch = 8'h58;
            6'd46: ch = 8'h43;
            6'd47: ch = 8'h56;
            6'd48: ch = 8'h42;
            6'd49: ch = 8'h4E;
            6'd50: ch = 8'h4D;
            6'd51: ch = 8'h3C;
            6'd52: ch = 8'h3E;
            6'd53: ch = 8'h3F;
            6'd57: ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Control table
    function automatic logic [7:0] ctrl_lookup(input logic [5:0] idx);
        logic [7:0] ch;
        case (idx)
            6'd12: ch = 8'h1F;
            6'd14: ch = 8'h08;
            6'd15: ch = 8'h09;
            6'd16: ch = 8'h11;
            6'd17: ch = 8'h17;
            6'd18: ch = 8'h05;
            6'd19: ch = 8'h12;
            6'd20: ch = 8'h14;
            6'd21: ch = 8'h19;
            6'd22: ch = 8'h15;
            6'd23: ch = 8'h09;
            6'd24: ch = 8'h0F;
            6'd25: ch = 8'h10;
            6'd26: ch = 8'h1B;
            6'd27: ch = 8'h1D;
            6'd28: ch = 8'h0A;
            6'd30: ch = 8'h01;
            6'd31: ch = 8'h13;
            6'd32: ch = 8'h04;
            6'd33: ch = 8'h06;
            6'd34: ch = 8'h07;
            6'd35: ch = 8'h08;
            6'd36: ch = 8'h0A;
            6'd37: ch = 8'h0B;
            6'd38: ch = 8'h0C;
            6'd43: ch = 8'h1C;
            6'd44: ch = 8'h1A;
            6'd45: ch = 8'h18;
            6'd46: ch = 8'h03;
            6'd47: ch = 8'h16;
            6'd48: ch = 8'h02;
            6'd49: ch = 8'h0E;
            6'd50: ch = 8'h0D;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> rtl/sc2a_xlate.sv
// Combinational translation of one scan byte against the current modifier flags.
// Produces the character and the flags after the byte.
// Depends on sc2a_pkg.
module sc2a_xlate (
    input  logic [7:0]      code,
    input  sc2a_pkg::flags_t flags_cur,
    output logic [7:0]      key_char,
    output sc2a_pkg::flags_t flags_nxt
);
    import sc2a_pkg::*;

    logic [5:0] idx;
    logic [6:0] rel_key;
    logic [7:0] plain_ch;
    logic [7:0] upper_ch;
    logic [7:0] ctrl_ch;

    assign idx      = code[5:0];
    assign rel_key  = code[6:0];
    assign plain_ch = plain_lookup(idx);
    assign upper_ch = upper_lookup(idx);
    assign ctrl_ch  = ctrl_lookup(idx);

    // Flag update and character select
    always_comb
    begin
        logic [7:0] ch;
        ch        = 8'h00;
        flags_nxt = flags_cur;
        key_char  = 8'h00;
        if (flags_cur.ext)
        begin
            // byte after prefix is swallowed
            flags_nxt.ext = 1'b0;
        end
        else if (code == SC_EXTPFX)
        begin
            flags_nxt.ext = 1'b1;
        end
        else if (code[7])
        begin
            // key release: clear matching modifier
            case ({1'b0, rel_key})
                SC_LSHIFT, SC_RSHIFT: flags_nxt.shift = 1'b0;
                SC_CAPS:              flags_nxt.caps  = 1'b0;
                SC_CTRL:              flags_nxt.ctrl  = 1'b0;
                SC_ALT:               flags_nxt.alt   = 1'b0;
                default:              flags_nxt.shift = flags_cur.shift;
            endcase
        end
        else if (code inside {SC_LSHIFT, SC_RSHIFT, SC_CAPS, SC_CTRL, SC_ALT})
        begin
            case (code)
                SC_LSHIFT, SC_RSHIFT: flags_nxt.shift = 1'b1;
                SC_CAPS:              flags_nxt.caps  = 1'b1;
                SC_CTRL:              flags_nxt.ctrl  = 1'b1;
                SC_ALT:               flags_nxt.alt   = 1'b1;
                default:              flags_nxt.shift = flags_cur.shift;
            endcase
        end
        else if (flags_cur.ctrl)
        begin
            // control wins; out of table gives nothing, no alt
            if (code < CTRL_LEN)
                key_char = flags_cur.alt ? ctrl_ch + ALT_OFFSET : ctrl_ch;
        end
        else if (flags_cur.shift)
        begin
            if (code < PLAIN_LEN)
            begin
                ch       = flags_cur.caps ? plain_ch : upper_ch;
                key_char = flags_cur.alt ? ch + ALT_OFFSET : ch;
            end
        end
        else
        begin
            // normal table (shifted table with caps); out of range still takes alt
            if (code < PLAIN_LEN)
                ch = flags_cur.caps ? upper_ch : plain_ch;
            key_char = flags_cur.alt ? ch + ALT_OFFSET : ch;
        end
    end

endmodule

>>> rtl/scancode_to_ascii_translator_unit.sv
// Top level of the scan code set 1 to ASCII translator.
// Input register, translation logic, result register and modifier flags.
// Depends on sc2a_pkg and sc2a_xlate.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------
//   input   | in_valid / in_stall  | scan_code[7:0]
//   output  | out_valid / out_stall| key_char[7:0], modifiers[4:0]
//
// One word per cycle sustained while the output is not stalled; the scan code is
// registered in the input stage, translated, and registered in the result stage.
// Reset clears the modifier flags and both valid bits.
// A stall on the output holds the result; the input stalls only when both
// stages are full and the output is stalled.
module scancode_to_ascii_translator_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] scan_code,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] key_char,
    output logic [4:0] modifiers
);
    import sc2a_pkg::*;

    logic       in_valid_reg;
    logic [7:0] code_reg;
    logic       out_valid_reg;
    logic [7:0] key_char_reg;
    logic [4:0] modifiers_reg;
    flags_t     flags_reg;
    flags_t     flags_next;
    logic [7:0] char_next;
    logic       out_load;
    logic       in_load;

    // Pipeline advance
    assign out_load = !out_valid_reg || !out_stall;
    assign in_load  = !in_valid_reg || out_load;
    assign in_stall = !in_load;

    // Translation
    sc2a_xlate u_xlate (
        .code      (code_reg),
        .flags_cur (flags_reg),
        .key_char  (char_next),
        .flags_nxt (flags_next)
    );

    // Input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_load)
            in_valid_reg <= in_valid;
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (in_load && in_valid)
            code_reg <= scan_code;
    end

    // Result stage control and modifier flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else if (out_load)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
                flags_reg <= flags_next;
        end
    end

    // Result stage payload
    always_ff @(posedge clk)
    begin
        if (out_load && in_valid_reg)
        begin
            key_char_reg  <= char_next;
            modifiers_reg <= flags_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign key_char  = key_char_reg;
    assign modifiers = modifiers_reg;

endmodule
